>>> hw/rtl/tbot_pkg.sv
// ============================================================================
// tbot_pkg
// Shared types and constants for the transformed box overlap test.
// ============================================================================
package tbot_pkg;

    // Commands and world axes
    localparam logic       CMD_REF    = 1'b0;
    localparam logic       CMD_CAND   = 1'b1;
    localparam logic [1:0] AXIS_X     = 2'd0;
    localparam logic [1:0] AXIS_Y     = 2'd1;
    localparam logic [1:0] AXIS_Z     = 2'd2;
    localparam logic [1:0] AXIS_NONE  = 2'd3;

    // Datapath widths: |coef| is 16 bits, size 24 bits, product Q28.12
    localparam int MAG_W      = 16;
    localparam int SIZE_W     = 24;
    localparam int PROD_W     = MAG_W + SIZE_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int EXT_SHIFT  = 13;
    localparam int EXT_W      = SUM_W - EXT_SHIFT;
    // Wide enough for min/max before saturation at the largest coordinate width
    localparam int CALC_W     = 50;

    // Defaults handed down from the top level
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIFO_DEPTH_DEF  = 4;

    // Input word
    typedef struct packed {
        logic                command;
        logic [1:0]          axis;
        logic signed [15:0]  coef_a;
        logic signed [15:0]  coef_b;
        logic signed [15:0]  coef_c;
        logic signed [31:0]  offset;
        logic [SIZE_W-1:0]   size_x;
        logic [SIZE_W-1:0]   size_y;
        logic [SIZE_W-1:0]   size_z;
    } tbot_in_t;

    // Result word
    typedef struct packed {
        logic                overlap;
        logic signed [31:0]  cand_min_x;
        logic signed [31:0]  cand_max_x;
        logic signed [31:0]  cand_min_y;
        logic signed [31:0]  cand_max_y;
        logic signed [31:0]  cand_min_z;
        logic signed [31:0]  cand_max_z;
    } tbot_out_t;

    // Classified row passed from front to back
    typedef struct packed {
        logic                command;
        logic [1:0]          axis;
        logic signed [31:0]  offset;
        logic [EXT_W-1:0]    ext;
    } tbot_row_t;

endpackage

>>> hw/rtl/tbot_fifo.sv
// ============================================================================
// tbot_fifo
// Short register queue of classified rows between front and back.
// ============================================================================
module tbot_fifo
    import tbot_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  tbot_row_t                         push_row,
    input  logic                              pop,
    output logic                              head_valid,
    output tbot_row_t                         head_row,
    output logic [$clog2(DEPTH+1)-1:0]        count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    tbot_row_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_row;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_row   = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(DEPTH)) || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count past depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count missed a write");

endmodule

>>> hw/rtl/tbot_front.sv
// ============================================================================
// tbot_front
// Accepts input words, drops rows with no axis, forms the half extent.
// ============================================================================
module tbot_front
    import tbot_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  tbot_in_t                           item,
    input  logic [$clog2(FIFO_DEPTH+1)-1:0]    fifo_count,
    output logic                               push,
    output tbot_row_t                          push_row
);

    localparam int CNT_W = $clog2(FIFO_DEPTH+1) + 1;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_cmd_reg;
    logic [1:0]            s1_axis_reg;
    logic signed [31:0]    s1_offset_reg;
    logic [PROD_W-1:0]     s1_prod_a_reg, s1_prod_b_reg, s1_prod_c_reg;
    logic [MAG_W-1:0]      mag_a, mag_b, mag_c;
    logic [SUM_W-1:0]      sum;
    logic                  accept;

    // Ready while the queue has room for everything in flight
    assign item_ready = (CNT_W'(fifo_count) + CNT_W'(s1_valid_reg)) < CNT_W'(FIFO_DEPTH);
    assign accept     = item_valid && item_ready;

    // Coefficient magnitudes; -32768 maps to 32768 unsigned
    assign mag_a = item.coef_a[15] ? MAG_W'(-item.coef_a) : MAG_W'(item.coef_a);
    assign mag_b = item.coef_b[15] ? MAG_W'(-item.coef_b) : MAG_W'(item.coef_b);
    assign mag_c = item.coef_c[15] ? MAG_W'(-item.coef_c) : MAG_W'(item.coef_c);

    // Rows with no axis leave no trace
    assign s1_valid_next = accept && (item.axis != AXIS_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Product stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= item.command;
            s1_axis_reg   <= item.axis;
            s1_offset_reg <= item.offset;
            s1_prod_a_reg <= PROD_W'(mag_a) * PROD_W'(item.size_x);
            s1_prod_b_reg <= PROD_W'(mag_b) * PROD_W'(item.size_y);
            s1_prod_c_reg <= PROD_W'(mag_c) * PROD_W'(item.size_z);
        end
    end

    // Sum, then drop 12 fraction bits and halve
    assign sum = SUM_W'(s1_prod_a_reg) + SUM_W'(s1_prod_b_reg) + SUM_W'(s1_prod_c_reg);

    assign push             = s1_valid_reg;
    assign push_row.command = s1_cmd_reg;
    assign push_row.axis    = s1_axis_reg;
    assign push_row.offset  = s1_offset_reg;
    assign push_row.ext     = sum[SUM_W-1:EXT_SHIFT];

endmodule

>>> hw/rtl/tbot_back.sv
// ============================================================================
// tbot_back
// Forms saturated bounds, keeps reference and candidate state, runs the test.
// ============================================================================
module tbot_back
    import tbot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  tbot_row_t   head_row,
    output logic        pop,
    output logic        result_valid,
    input  logic        result_ready,
    output tbot_out_t   result
);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam logic signed [CALC_W-1:0] SAT_HI =
        (CALC_W'(1) <<< (COORD_WIDTH-1)) - CALC_W'(1);
    localparam logic signed [CALC_W-1:0] SAT_LO = -SAT_HI - CALC_W'(1);

    coord_t                 ref_min_reg [3];
    coord_t                 ref_max_reg [3];
    coord_t                 cand_min_reg [2];
    coord_t                 cand_max_reg [2];
    logic                   result_valid_reg, result_valid_next;
    tbot_out_t              result_reg;

    logic signed [CALC_W-1:0] off_w, ext_w, lo_w, hi_w;
    coord_t                 lo, hi;
    logic                   is_result, out_free, overlap;

    function automatic logic [31:0] to_out(input coord_t v);
        logic signed [CALC_W-1:0] w;
        w = CALC_W'(v);
        return w[31:0];
    endfunction

    // Bounds with saturation to the coordinate range
    assign off_w = CALC_W'(head_row.offset);
    assign ext_w = CALC_W'(head_row.ext);
    assign lo_w  = off_w - ext_w;
    assign hi_w  = off_w + ext_w;

    always_comb
    begin
        priority if (lo_w > SAT_HI) lo = COORD_WIDTH'(SAT_HI);
        else if (lo_w < SAT_LO)     lo = COORD_WIDTH'(SAT_LO);
        else                        lo = COORD_WIDTH'(lo_w);
        priority if (hi_w > SAT_HI) hi = COORD_WIDTH'(SAT_HI);
        else if (hi_w < SAT_LO)     hi = COORD_WIDTH'(SAT_LO);
        else                        hi = COORD_WIDTH'(hi_w);
    end

    // A candidate z row completes a box and needs the output register
    assign is_result = (head_row.command == CMD_CAND) && (head_row.axis == AXIS_Z);
    assign out_free  = !result_valid_reg || result_ready;
    assign pop       = head_valid && (!is_result || out_free);

    // Interval test on all three axes, touching counts
    assign overlap = (cand_min_reg[0] <= ref_max_reg[0]) && (cand_max_reg[0] >= ref_min_reg[0])
                  && (cand_min_reg[1] <= ref_max_reg[1]) && (cand_max_reg[1] >= ref_min_reg[1])
                  && (lo <= ref_max_reg[2]) && (hi >= ref_min_reg[2]);

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (pop && is_result)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    // Box state, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                ref_min_reg[i] <= '0;
                ref_max_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++)
            begin
                cand_min_reg[i] <= '0;
                cand_max_reg[i] <= '0;
            end
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (pop)
            begin
                unique case (head_row.command)
                    CMD_REF:
                    begin
                        ref_min_reg[head_row.axis] <= lo;
                        ref_max_reg[head_row.axis] <= hi;
                    end
                    CMD_CAND:
                    begin
                        if (!is_result)
                        begin
                            cand_min_reg[head_row.axis[0]] <= lo;
                            cand_max_reg[head_row.axis[0]] <= hi;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (pop && is_result)
        begin
            result_reg.overlap    <= overlap;
            result_reg.cand_min_x <= to_out(cand_min_reg[0]);
            result_reg.cand_max_x <= to_out(cand_max_reg[0]);
            result_reg.cand_min_y <= to_out(cand_min_reg[1]);
            result_reg.cand_max_y <= to_out(cand_max_reg[1]);
            result_reg.cand_min_z <= to_out(lo);
            result_reg.cand_max_z <= to_out(hi);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

>>> hw/rtl/transformed_box_overlap_test.sv
// ============================================================================
// transformed_box_overlap_test
// World-space bounds of transformed boxes and an overlap test against a
// stored reference box.
// ============================================================================
// Usage:
//   item channel (item_valid/item_ready/item): one transform row per word.
//   command 0 loads a reference row, command 1 a candidate row; axis 3 rows
//   are dropped. Every candidate z row yields one word on the result channel
//   (result_valid/result_ready/result) with the candidate bounds, the x/y
//   bounds being those of the latest candidate x/y rows.
//   A candidate z row passes the product stage, the queue and the result
//   register before its result shows.
//   Throughput: one word per cycle while item_ready is high; the three
//   16x24 multipliers of the product stage and the single bound/compare
//   step of the back end each take one row per cycle unless results stall.
//   A stalled receiver holds the result register; rows keep flowing into
//   the 4-entry queue and reference/candidate x/y rows keep draining, until
//   a z row waits at the queue head and the queue fills, then item_ready
//   drops.
//   Reset clears the reference and candidate bounds to zero and empties
//   the queue.
// ============================================================================
module transformed_box_overlap_test
    import tbot_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  tbot_in_t   item,
    output logic       result_valid,
    input  logic       result_ready,
    output tbot_out_t  result
);

    logic                              push, pop, head_valid;
    tbot_row_t                         push_row, head_row;
    logic [$clog2(FIFO_DEPTH+1)-1:0]   fifo_count;

    // Front: accept and classify
    tbot_front #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .fifo_count (fifo_count),
        .push       (push),
        .push_row   (push_row)
    );

    // Queue between the two halves
    tbot_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_row   (push_row),
        .pop        (pop),
        .head_valid (head_valid),
        .head_row   (head_row),
        .count      (fifo_count)
    );

    // Back: bounds, state and overlap test
    tbot_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_row     (head_row),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
